// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/ssb_pkg.sv =====
// ----------------------------------------------------------------------------
// ssb_pkg
// Sizes, command codes, register indexes and shared helpers of the sieve
// segment.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int SEG_SIZE  = 1024;
  localparam int WORD_W    = 64;
  localparam int OFF_W     = 6;
  localparam int NUM_WORDS = (SEG_SIZE + WORD_W - 1) / WORD_W;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = $clog2(SEG_SIZE);
  localparam int CNT_W     = $clog2(SEG_SIZE + 1);
  localparam int HIT_W     = WORD_AW + OFF_W;

  localparam logic [2:0] KIND_MARK    = 3'd0;
  localparam logic [2:0] KIND_TEST    = 3'd1;
  localparam logic [2:0] KIND_REFILL  = 3'd2;
  localparam logic [2:0] KIND_REWIND  = 3'd3;
  localparam logic [2:0] KIND_ADVANCE = 3'd4;
  localparam logic [2:0] KIND_COUNT   = 3'd5;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_START = 1'b1;

  typedef struct packed {
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               clear;
  } bm_req_t;

  function automatic logic [WORD_AW-1:0] word_of(input logic [IDX_W-1:0] idx);
    return WORD_AW'(idx >> OFF_W);
  endfunction

  // Lowest set bit of a word: found flag above the bit position.
  function automatic logic [OFF_W:0] first_set(input logic [WORD_W-1:0] w);
    logic [OFF_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = {1'b1, OFF_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== design/sieve_segment_bitmap.sv =====
// ----------------------------------------------------------------------------
// sieve_segment_bitmap
// One segment of a segmented prime sieve with a cursor and a running count.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. busy stays high
// until the single cycle in which done is high and the result is on the output
// ports. busy is already low in that cycle, so the next transaction can be
// taken at its end. The receiver cannot stall, so it must take the result in
// that cycle. All searches run through one scan unit that reads the flag
// memory one 64-bit word per cycle. Each scan has a setup step and then visits
// up to 16 words at the default segment size. A mark or test does a lookup, a
// modify step and one scan, and skips the modify step when the number is out
// of range. Refill and count do one scan, and rewind or advance do up to two
// scans that together visit at most 17 words. Reset and refill clear per-word
// valid bits, so there is no clearing pass.
module sieve_segment_bitmap
  import ssb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [47:0] number,
  output logic        done,
  output logic        in_range,
  output logic        is_candidate,
  output logic        found,
  output logic [47:0] position,
  output logic        has_more,
  output logic [32:0] count,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [47:0] wr_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOKUP = 6'b000010,
    S_MODIFY = 6'b000100,
    S_SETUP  = 6'b001000,
    S_SCAN   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [2:0]         kind_q;
  logic [47:0]        number_q;
  logic [IDX_W-1:0]   idx_q;
  logic               in_range_q;
  logic               is_cand_q;
  logic               found_q;
  logic               has_more_q;
  logic [IDX_W-1:0]   cursor;
  logic [CNT_W-1:0]   set_total;
  logic [47:0]        seg_base;
  logic [31:0]        start_cnt;
  logic [IDX_W:0]     scan_from;
  logic [WORD_AW-1:0] scan_word;
  logic               scan_first;
  logic               seek;

  bm_req_t            bm_req;
  logic [WORD_W-1:0]  rd_word;
  logic               accept;
  logic [48:0]        diff;
  logic               lk_in_range;
  logic [IDX_W-1:0]   lk_idx;
  logic               cur_bit;
  logic [WORD_W-1:0]  first_mask;
  logic [OFF_W:0]     pe;
  logic [HIT_W-1:0]   hit;
  logic               hit_ok;
  logic               from_out;
  logic               scan_done;
  logic               scan_found;
  logic [IDX_W:0]     cursor_inc;

  ssb_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .req     (bm_req),
    .rd_word (rd_word)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign cursor_inc = {1'b0, cursor} + 1'b1;

  always_comb begin
    diff        = {1'b0, number_q} - {1'b0, seg_base};
    lk_in_range = !diff[48] && (diff[47:0] < 48'(SEG_SIZE));
    lk_idx      = diff[IDX_W-1:0];
    cur_bit     = rd_word[idx_q[OFF_W-1:0]];
    first_mask  = scan_first ? ({WORD_W{1'b1}} << scan_from[OFF_W-1:0]) : '1;
    pe          = first_set(rd_word & first_mask);
    hit         = {scan_word, pe[OFF_W-1:0]};
    hit_ok      = pe[OFF_W] && ((HIT_W + 1)'(hit) < (HIT_W + 1)'(SEG_SIZE));
    from_out    = (scan_from >= (IDX_W + 1)'(SEG_SIZE));
    scan_found  = (state == S_SCAN) && hit_ok;
    scan_done   = ((state == S_SETUP) && from_out) ||
                  ((state == S_SCAN) &&
                   (pe[OFF_W] || (scan_word == WORD_AW'(NUM_WORDS - 1))));

    bm_req         = '0;
    bm_req.rd_addr = scan_word;
    bm_req.wr_addr = word_of(idx_q);
    bm_req.wr_data = rd_word & ~({{(WORD_W - 1){1'b0}}, 1'b1} << idx_q[OFF_W-1:0]);
    case (state)
      S_IDLE: begin
        bm_req.clear = accept && (kind == KIND_REFILL);
      end
      S_LOOKUP: begin
        bm_req.rd_addr = word_of(lk_idx);
      end
      S_MODIFY: begin
        bm_req.wr_en = (kind_q == KIND_MARK) && in_range_q && cur_bit;
      end
      S_SETUP: begin
        bm_req.rd_addr = word_of(scan_from[IDX_W-1:0]);
      end
      S_SCAN: begin
        bm_req.rd_addr = WORD_AW'(scan_word + 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_MARK || kind == KIND_TEST) begin
            state_next = S_LOOKUP;
          end else begin
            state_next = S_SETUP;
          end
        end
      end
      S_LOOKUP: begin
        state_next = lk_in_range ? S_MODIFY : S_SETUP;
      end
      S_MODIFY: begin
        state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = from_out ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = (seek && scan_found) ? S_SETUP : S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      set_total <= CNT_W'(SEG_SIZE);
      seg_base  <= '0;
      start_cnt <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;

      if (wr_en) begin
        case (wr_index)
          REG_BASE:  seg_base  <= wr_data;
          REG_START: start_cnt <= wr_data[31:0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q     <= kind;
            number_q   <= number;
            in_range_q <= 1'b0;
            is_cand_q  <= 1'b0;
            found_q    <= 1'b0;
            has_more_q <= 1'b0;
            scan_from  <= cursor_inc;
            seek       <= 1'b0;
            case (kind)
              KIND_REFILL: begin
                set_total <= CNT_W'(SEG_SIZE);
              end
              KIND_REWIND: begin
                cursor    <= '0;
                scan_from <= '0;
                seek      <= 1'b1;
              end
              KIND_ADVANCE: begin
                seek <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_LOOKUP: begin
          in_range_q <= lk_in_range;
          idx_q      <= lk_idx;
        end
        S_MODIFY: begin
          if (kind_q == KIND_TEST) begin
            is_cand_q <= cur_bit;
          end
          if (bm_req.wr_en) begin
            set_total <= set_total - 1'b1;
          end
        end
        S_SETUP: begin
          scan_word  <= word_of(scan_from[IDX_W-1:0]);
          scan_first <= 1'b1;
        end
        S_SCAN: begin
          scan_word  <= WORD_AW'(scan_word + 1'b1);
          scan_first <= 1'b0;
        end
        S_FINISH: begin
          done         <= 1'b1;
          in_range     <= in_range_q;
          is_candidate <= is_cand_q;
          found        <= found_q;
          has_more     <= has_more_q;
          count        <= 33'(start_cnt) + 33'(set_total);
          if (kind_q == KIND_REWIND || kind_q == KIND_ADVANCE) begin
            position <= seg_base + 48'(cursor);
          end else begin
            position <= '0;
          end
        end
        default: begin
        end
      endcase

      if (scan_done) begin
        if (seek) begin
          if (scan_found) begin
            cursor    <= IDX_W'(hit);
            found_q   <= 1'b1;
            scan_from <= (IDX_W + 1)'(hit) + 1'b1;
            seek      <= 1'b0;
          end else begin
            has_more_q <= 1'b0;
          end
        end else begin
          has_more_q <= scan_found;
        end
      end
    end
  end

endmodule

// ===== design/ssb_bitmap.sv =====
// ----------------------------------------------------------------------------
// ssb_bitmap
// Flag storage: a word memory with one valid bit per word. A word that is not
// valid reads as all ones, so reset and refill take effect at once.
// ----------------------------------------------------------------------------
module ssb_bitmap
  import ssb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  bm_req_t           req,
  output logic [WORD_W-1:0] rd_word
);

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid;
  logic [WORD_W-1:0]    rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[req.rd_addr];
      if (req.clear) begin
        valid <= '0;
      end else if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_word = rd_valid ? rd_data : '1;

endmodule

// ===== design/ssb_checker.sv =====
// ----------------------------------------------------------------------------
// ssb_checker
// Port-level checks of the sieve segment handshake and result fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic in_range,
  input logic is_candidate,
  input logic found
);

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_NEXT(a_accept_no_done, start && !busy, !done)
  `ASSERT_IMPLY(a_done_idle, done, !busy)
  `ASSERT_NEXT(a_done_single, done, !done)
  `ASSERT_IMPLY(a_fields_exclusive, done && (in_range || is_candidate), in_range && !found)

endmodule

bind sieve_segment_bitmap ssb_checker u_ssb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .in_range     (in_range),
  .is_candidate (is_candidate),
  .found        (found)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of sieve_segment_bitmap. A behavioral copy of the segment (flags,
// cursor, set total and both registers) predicts the answer of every accepted
// transaction, and a checker compares each done strobe with the oldest
// prediction field by field. Directed tests cover reset state, a segment that
// wraps at the top of the 48-bit range and the range edges; random phases
// then mix all kinds, and one phase clears the whole segment so that scans
// run off the end and rewind finds nothing.
// ----------------------------------------------------------------------------
module tb;
  import ssb_pkg::*;

  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic        in_range;
    logic        is_candidate;
    logic        found;
    logic [47:0] position;
    logic        has_more;
    logic [32:0] count;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  kind;
  logic [47:0] number;
  logic        done;
  logic        in_range;
  logic        is_candidate;
  logic        found;
  logic [47:0] position;
  logic        has_more;
  logic [32:0] count;
  logic        wr_en;
  logic        wr_index;
  logic [47:0] wr_data;

  bit   [SEG_SIZE-1:0] flags;
  logic [IDX_W-1:0]    cur_idx;
  int                  set_total;
  logic [47:0]         seg_base;
  logic [31:0]         seg_start;
  answer_t             pending_answers[$];
  answer_t             oldest;
  int                  errors;
  int                  burst_left;
  int                  cycle_count;

  sieve_segment_bitmap uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .number       (number),
    .done         (done),
    .in_range     (in_range),
    .is_candidate (is_candidate),
    .found        (found),
    .position     (position),
    .has_more     (has_more),
    .count        (count),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int next_set(input int from);
    for (int i = from; i < SEG_SIZE; i++) begin
      if (flags[i]) return i;
    end
    return SEG_SIZE;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [2:0] pick_kind(input bit with_refill);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return KIND_MARK;
    if (r < 55) return KIND_TEST;
    if (r < 75) return KIND_ADVANCE;
    if (r < 82) return KIND_REWIND;
    if (r < 88) return KIND_COUNT;
    if (r < 93) return with_refill ? KIND_REFILL : KIND_TEST;
    return r[0] ? KIND_SPARE6 : KIND_SPARE7;
  endfunction

  // Mostly numbers inside the segment, the rest just outside it or anywhere.
  function automatic logic [47:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return seg_base + 48'($urandom_range(0, SEG_SIZE - 1));
    if (r < 88) return rand48();
    if (r < 94) return seg_base - 48'($urandom_range(1, 3));
    return seg_base + 48'(SEG_SIZE + $urandom_range(0, 3));
  endfunction

  task automatic predict_answer(input logic [2:0] k, input logic [47:0] n);
    answer_t     a;
    int          hit;
    logic        hit_ok;
    logic [47:0] offset;
    a = '0;
    offset = n - seg_base;
    hit_ok = (n >= seg_base) && (offset < 48'(SEG_SIZE));
    case (k)
      KIND_MARK: begin
        if (hit_ok) begin
          a.in_range = 1'b1;
          if (flags[offset[IDX_W-1:0]]) begin
            flags[offset[IDX_W-1:0]] = 1'b0;
            set_total--;
          end
        end
      end
      KIND_TEST: begin
        if (hit_ok) begin
          a.in_range = 1'b1;
          a.is_candidate = flags[offset[IDX_W-1:0]];
        end
      end
      KIND_REFILL: begin
        flags = '1;
        set_total = SEG_SIZE;
      end
      KIND_REWIND: begin
        cur_idx = '0;
        hit = next_set(0);
        if (hit < SEG_SIZE) begin
          cur_idx = IDX_W'(hit);
          a.found = 1'b1;
        end
        a.position = seg_base + 48'(cur_idx);
      end
      KIND_ADVANCE: begin
        hit = next_set(int'(cur_idx) + 1);
        if (hit < SEG_SIZE) begin
          cur_idx = IDX_W'(hit);
          a.found = 1'b1;
        end
        a.position = seg_base + 48'(cur_idx);
      end
      default: ;
    endcase
    a.has_more = next_set(int'(cur_idx) + 1) < SEG_SIZE;
    a.count = 33'(seg_start) + 33'(set_total);
    pending_answers.push_back(a);
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result strobe with no transaction pending");
        errors++;
      end else begin
        oldest = pending_answers.pop_front();
        check_field("in_range", 48'(oldest.in_range), 48'(in_range));
        check_field("is_candidate", 48'(oldest.is_candidate), 48'(is_candidate));
        check_field("found", 48'(oldest.found), 48'(found));
        check_field("position", oldest.position, position);
        check_field("has_more", 48'(oldest.has_more), 48'(has_more));
        check_field("count", 48'(oldest.count), 48'(count));
      end
    end
  end

  // Offers one transaction and holds it until the block takes it. The sender
  // works in bursts, and a gap of random length follows each burst.
  task automatic send_item(input logic [2:0] k, input logic [47:0] n);
    int gap;
    int r;
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    number <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_answer(k, n);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      r = $urandom_range(0, 99);
      gap = (r < 25) ? 0 : (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 45);
      if (gap > 0) begin
        @(negedge clk) start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk) start <= 1'b0;
    while (pending_answers.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [47:0] value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    if (idx == REG_BASE) seg_base = value;
    else seg_start = value[31:0];
    @(negedge clk) wr_en <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(KIND_COUNT, 48'd0);
    send_item(KIND_TEST, 48'd0);
    send_item(KIND_TEST, 48'd1023);
    send_item(KIND_TEST, 48'd1024);
    send_item(KIND_ADVANCE, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_MARK, 48'd1023);
  endtask

  // The first flag sits on the largest number, so every later position wraps.
  task automatic test_wrapped_segment();
    wait_idle();
    reg_write(REG_BASE, 48'hFFFF_FFFF_FFFF);
    reg_write(REG_START, 48'h0000_FFFF_FFFF);
    send_item(KIND_TEST, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_TEST, 48'd0);
    send_item(KIND_MARK, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_MARK, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_REWIND, 48'd0);
    send_item(KIND_ADVANCE, 48'd0);
    send_item(KIND_COUNT, 48'd0);
    send_item(KIND_SPARE6, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_SPARE7, 48'd0);
    send_item(KIND_REFILL, 48'd0);
    send_item(KIND_REWIND, 48'd0);
  endtask

  task automatic test_range_edges();
    wait_idle();
    reg_write(REG_BASE, 48'h8000_0000_0000);
    reg_write(REG_START, 48'h0000_5555_5555);
    send_item(KIND_MARK, 48'h7FFF_FFFF_FFFF);
    send_item(KIND_MARK, 48'h8000_0000_0000 + 48'(SEG_SIZE));
    send_item(KIND_MARK, 48'h8000_0000_0000 + 48'(SEG_SIZE - 1));
    send_item(KIND_TEST, 48'h8000_0000_0000 + 48'(SEG_SIZE - 1));
    send_item(KIND_COUNT, 48'd0);
  endtask

  task automatic test_random_mix(input logic [47:0] b, input logic [31:0] s,
                                 input int items);
    logic [2:0] k;
    wait_idle();
    reg_write(REG_BASE, b);
    reg_write(REG_START, 48'(s));
    for (int i = 0; i < items; i++) begin
      k = pick_kind(1'b1);
      send_item(k, (k == KIND_MARK || k == KIND_TEST) ? pick_number() : rand48());
    end
  endtask

  // Marks every flag of the segment in random order, with other kinds mixed
  // in, until rewind and advance find nothing left; then refills and scans again.
  task automatic test_full_clear();
    int          order[SEG_SIZE];
    int          j;
    int          t;
    logic [47:0] b;
    logic [2:0]  k;
    b = rand48();
    if (b > 48'hFFFF_FFFF_FC00) b = b - 48'(SEG_SIZE);
    wait_idle();
    reg_write(REG_BASE, b);
    reg_write(REG_START, 48'($urandom));
    send_item(KIND_REFILL, rand48());
    send_item(KIND_REWIND, rand48());
    for (int i = 0; i < SEG_SIZE; i++) order[i] = i;
    for (int i = SEG_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < SEG_SIZE; i++) begin
      while ($urandom_range(0, 99) < 2) begin
        k = pick_kind(1'b0);
        if (k == KIND_MARK) send_item(k, seg_base - 48'($urandom_range(1, 1000)));
        else if (k == KIND_TEST) send_item(k, pick_number());
        else send_item(k, rand48());
      end
      send_item(KIND_MARK, seg_base + 48'(order[i]));
    end
    send_item(KIND_REWIND, rand48());
    send_item(KIND_ADVANCE, rand48());
    send_item(KIND_TEST, seg_base);
    send_item(KIND_COUNT, rand48());
    send_item(KIND_REFILL, rand48());
    send_item(KIND_ADVANCE, rand48());
    send_item(KIND_REWIND, rand48());
    send_item(KIND_ADVANCE, rand48());
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_MARK;
    number = '0;
    wr_en = 1'b0;
    wr_index = REG_BASE;
    wr_data = '0;
    errors = 0;
    cycle_count = 0;
    burst_left = 0;
    flags = '1;
    cur_idx = '0;
    set_total = SEG_SIZE;
    seg_base = '0;
    seg_start = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_state();
    test_wrapped_segment();
    test_range_edges();
    test_random_mix(48'd0, 32'd0, 20);
    test_random_mix(rand48(), $urandom, 20);
    test_random_mix(48'hFFFF_FFFF_FE00, 32'hFFFF_FFFF, 10);
    test_full_clear();

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sieve_segment_bitmap.f =====
+incdir+design
design/ssb_pkg.sv
design/ssb_bitmap.sv
design/sieve_segment_bitmap.sv
design/ssb_checker.sv
dv/tb.sv
